// File: src/csvfs_pkg.sv
package csvfs_pkg;

  typedef struct packed {
    logic       command;
    logic [7:0] char_in;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_out;
    logic       trim_overflow;
    logic       last_of_run;
  } result_t;

  localparam logic CMD_CHAR     = 1'b0;
  localparam logic CMD_LINE_END = 1'b1;

  localparam logic [1:0] KIND_CONTENT  = 2'd0;
  localparam logic [1:0] KIND_END      = 2'd1;
  localparam logic [1:0] KIND_LINE_END = 2'd2;

  localparam logic [7:0] QUOTE_CHAR = 8'h22;
  localparam logic [7:0] COMMA_CHAR = 8'h2C;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] TAB_CHAR   = 8'h09;
  localparam logic [7:0] CR_CHAR    = 8'h0D;

  // What an accepted item does to the field state
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_APPEND,
    ACT_OVERFLOW,
    ACT_CONTENT,
    ACT_END,
    ACT_LINE_END
  } action_t;

  typedef enum logic [2:0] {
    SEL_CHAR,
    SEL_HEAD,
    SEL_HELD,
    SEL_END,
    SEL_LINE_END
  } out_sel_t;

  typedef enum logic {
    ST_IDLE,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic     take;
    logic     pop;
    logic     load_out;
    out_sel_t sel;
    logic     last;
  } dp_cmd_t;

  typedef struct packed {
    action_t action;
    logic    buf_empty;
    logic    slot_free;
  } dp_status_t;

endpackage

// File: src/csvfs_ctrl.sv
module csvfs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  csvfs_pkg::dp_status_t status,
  output csvfs_pkg::dp_cmd_t    cmd
);

  csvfs_pkg::state_t state;
  csvfs_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csvfs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      csvfs_pkg::ST_IDLE: begin
        if (item_valid && status.slot_free && status.action == csvfs_pkg::ACT_CONTENT &&
            !status.buf_empty) begin
          state_next = csvfs_pkg::ST_FLUSH;
        end
      end
      csvfs_pkg::ST_FLUSH: begin
        if (status.slot_free && status.buf_empty) begin
          state_next = csvfs_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    item_ready   = 1'b0;
    cmd.take     = 1'b0;
    cmd.pop      = 1'b0;
    cmd.load_out = 1'b0;
    cmd.sel      = csvfs_pkg::SEL_CHAR;
    cmd.last     = 1'b1;
    unique case (state)
      csvfs_pkg::ST_IDLE: begin
        item_ready = status.slot_free;
        if (item_valid && status.slot_free) begin
          cmd.take = 1'b1;
          unique case (status.action)
            csvfs_pkg::ACT_NONE, csvfs_pkg::ACT_APPEND: begin
            end
            csvfs_pkg::ACT_OVERFLOW: begin
              // emit the oldest buffered byte early
              cmd.load_out = 1'b1;
              cmd.sel      = csvfs_pkg::SEL_HEAD;
              cmd.pop      = 1'b1;
            end
            csvfs_pkg::ACT_CONTENT: begin
              cmd.load_out = 1'b1;
              if (status.buf_empty) begin
                cmd.sel = csvfs_pkg::SEL_CHAR;
              end else begin
                cmd.sel  = csvfs_pkg::SEL_HEAD;
                cmd.pop  = 1'b1;
                cmd.last = 1'b0;
              end
            end
            csvfs_pkg::ACT_END: begin
              cmd.load_out = 1'b1;
              cmd.sel      = csvfs_pkg::SEL_END;
            end
            csvfs_pkg::ACT_LINE_END: begin
              cmd.load_out = 1'b1;
              cmd.sel      = csvfs_pkg::SEL_LINE_END;
            end
            default: begin
            end
          endcase
        end
      end
      csvfs_pkg::ST_FLUSH: begin
        if (status.slot_free) begin
          cmd.load_out = 1'b1;
          if (status.buf_empty) begin
            cmd.sel = csvfs_pkg::SEL_HELD;
          end else begin
            cmd.sel  = csvfs_pkg::SEL_HEAD;
            cmd.pop  = 1'b1;
            cmd.last = 1'b0;
          end
        end
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_take_in_flush: assert property (@(posedge clk) disable iff (rst)
    state == csvfs_pkg::ST_FLUSH |-> !item_ready && !cmd.take)
    else $error("item taken during flush");
  a_flush_exits_on_last: assert property (@(posedge clk) disable iff (rst)
    (state == csvfs_pkg::ST_FLUSH && state_next == csvfs_pkg::ST_IDLE) |->
      (cmd.load_out && cmd.last && cmd.sel == csvfs_pkg::SEL_HELD))
    else $error("flush left without final byte");
  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> cmd.load_out && cmd.sel == csvfs_pkg::SEL_HEAD)
    else $error("buffer popped without transfer");
`endif

endmodule

// File: src/csvfs_datapath.sv
module csvfs_datapath #(
  parameter int SPACE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  csvfs_pkg::item_t      item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output csvfs_pkg::result_t    result,
  input  csvfs_pkg::dp_cmd_t    cmd,
  output csvfs_pkg::dp_status_t status
);

  localparam int PW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;
  localparam int CW = $clog2(SPACE_DEPTH + 1);
  localparam int SW = CW + 1;

  logic           quoting;
  logic           quote_pending;
  logic           field_has_content;
  logic           overflow_seen;
  logic [CW-1:0]  count;
  logic [PW-1:0]  head;
  logic [7:0]     rd_data;
  logic [7:0]     held;
  logic [7:0]     space_mem [SPACE_DEPTH];

  logic           quoting_next;
  logic           quote_pending_next;
  logic [PW-1:0]  head_inc;
  logic [PW-1:0]  rd_addr;
  logic [PW-1:0]  tail;
  logic [SW-1:0]  tail_sum;
  logic           full;
  logic           push;
  logic           is_quote;
  logic           is_comma;
  logic           is_space;
  csvfs_pkg::action_t content_act;
  csvfs_pkg::action_t action;
  logic [7:0]     c;

  assign c        = item.char_in;
  assign is_quote = (c == csvfs_pkg::QUOTE_CHAR);
  assign is_comma = (c == csvfs_pkg::COMMA_CHAR);
  assign is_space = (c == csvfs_pkg::SPACE_CHAR) ||
                    (c >= csvfs_pkg::TAB_CHAR && c <= csvfs_pkg::CR_CHAR);
  assign full     = (count == CW'(SPACE_DEPTH));

  always_comb begin
    priority if (is_space && !field_has_content) begin
      content_act = csvfs_pkg::ACT_NONE;
    end else if (is_space && full) begin
      content_act = csvfs_pkg::ACT_OVERFLOW;
    end else if (is_space) begin
      content_act = csvfs_pkg::ACT_APPEND;
    end else begin
      content_act = csvfs_pkg::ACT_CONTENT;
    end
  end

  always_comb begin
    quoting_next       = quoting;
    quote_pending_next = quote_pending;
    priority if (item.command == csvfs_pkg::CMD_LINE_END) begin
      action             = csvfs_pkg::ACT_LINE_END;
      quoting_next       = 1'b0;
      quote_pending_next = 1'b0;
    end else if (quote_pending) begin
      quote_pending_next = 1'b0;
      priority if (is_quote) begin
        // doubled quote: one literal quote, stay quoted
        action = content_act;
      end else if (is_comma) begin
        quoting_next = 1'b0;
        action       = csvfs_pkg::ACT_END;
      end else begin
        quoting_next = 1'b0;
        action       = content_act;
      end
    end else if (quoting) begin
      if (is_quote) begin
        quote_pending_next = 1'b1;
        action             = csvfs_pkg::ACT_NONE;
      end else begin
        action = content_act;
      end
    end else begin
      priority if (is_quote) begin
        quoting_next = 1'b1;
        action       = csvfs_pkg::ACT_NONE;
      end else if (is_comma) begin
        action = csvfs_pkg::ACT_END;
      end else begin
        action = content_act;
      end
    end
  end

  assign status.action    = action;
  assign status.buf_empty = (count == '0);
  assign status.slot_free = !result_valid || result_ready;

  assign push = cmd.take &&
                (action == csvfs_pkg::ACT_APPEND || action == csvfs_pkg::ACT_OVERFLOW);

  assign head_inc = (head == PW'(SPACE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign rd_addr  = cmd.pop ? head_inc : head;
  assign tail_sum = SW'(head) + SW'(count);
  assign tail     = (tail_sum >= SW'(SPACE_DEPTH)) ? PW'(tail_sum - SW'(SPACE_DEPTH))
                                                   : PW'(tail_sum);

  // Whitespace buffer, circular, with the head byte prefetched into rd_data
  always_ff @(posedge clk) begin
    if (push) begin
      space_mem[tail] <= c;
    end
    if (push && tail == rd_addr) begin
      rd_data <= c;
    end else begin
      rd_data <= space_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quoting           <= 1'b0;
      quote_pending     <= 1'b0;
      field_has_content <= 1'b0;
      overflow_seen     <= 1'b0;
      count             <= '0;
      head              <= '0;
    end else begin
      if (cmd.take) begin
        quoting       <= quoting_next;
        quote_pending <= quote_pending_next;
      end
      if (cmd.pop) begin
        head <= head_inc;
      end
      if (cmd.take && (action == csvfs_pkg::ACT_END || action == csvfs_pkg::ACT_LINE_END)) begin
        // drop buffered trailing whitespace
        count             <= '0;
        field_has_content <= 1'b0;
        overflow_seen     <= 1'b0;
      end else begin
        if (push && !cmd.pop) begin
          count <= count + 1'b1;
        end else if (cmd.pop && !push) begin
          count <= count - 1'b1;
        end
        if (cmd.take && action == csvfs_pkg::ACT_OVERFLOW) begin
          overflow_seen <= 1'b1;
        end else if (cmd.take && action == csvfs_pkg::ACT_CONTENT) begin
          overflow_seen     <= 1'b0;
          field_has_content <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      held <= c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.last_of_run <= cmd.last;
      unique case (cmd.sel)
        csvfs_pkg::SEL_CHAR: begin
          result.kind          <= csvfs_pkg::KIND_CONTENT;
          result.char_out      <= c;
          result.trim_overflow <= 1'b0;
        end
        csvfs_pkg::SEL_HEAD: begin
          result.kind          <= csvfs_pkg::KIND_CONTENT;
          result.char_out      <= rd_data;
          result.trim_overflow <= 1'b0;
        end
        csvfs_pkg::SEL_HELD: begin
          result.kind          <= csvfs_pkg::KIND_CONTENT;
          result.char_out      <= held;
          result.trim_overflow <= 1'b0;
        end
        csvfs_pkg::SEL_END: begin
          result.kind          <= csvfs_pkg::KIND_END;
          result.char_out      <= '0;
          result.trim_overflow <= overflow_seen;
        end
        csvfs_pkg::SEL_LINE_END: begin
          result.kind          <= csvfs_pkg::KIND_LINE_END;
          result.char_out      <= '0;
          result.trim_overflow <= overflow_seen;
        end
        default: begin
          result.kind          <= csvfs_pkg::KIND_CONTENT;
          result.char_out      <= '0;
          result.trim_overflow <= 1'b0;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(SPACE_DEPTH))
    else $error("whitespace count above depth");
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> count != '0)
    else $error("pop from empty whitespace buffer");
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    (push && !cmd.pop) |-> count < CW'(SPACE_DEPTH))
    else $error("push into full whitespace buffer");
  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!result_valid || result_ready))
    else $error("result register overwritten");
`endif

endmodule

// File: src/csv_field_splitter.sv
// Channel  Direction  Payload              Handshake
// item     in         csvfs_pkg::item_t    item_valid / item_ready
// result   out        csvfs_pkg::result_t  result_valid / result_ready
//
// An item that yields zero or one result is taken without entering the flush state.
// A content byte that follows buffered whitespace bytes is emitted after them:
// the buffer has one read port and gives one byte per cycle while the result register has room.
// Reset (rst, synchronous) clears quote, field and buffer-count state; the
// buffer bytes themselves are not cleared and need no clearing pass.
// A full result register that is not being taken holds item_ready low.
module csv_field_splitter #(
  parameter int SPACE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  csvfs_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_ready,
  output csvfs_pkg::result_t result
);

  csvfs_pkg::dp_cmd_t    cmd;
  csvfs_pkg::dp_status_t status;

  csvfs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  csvfs_datapath #(
    .SPACE_DEPTH (SPACE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cmd          (cmd),
    .status       (status)
  );

endmodule
